// ----- src/pbd_pkg.sv -----
// ============================================================================
// pbd_pkg: shared types and constants for the bearing and distance block
// Fixed-point formats, the arctangent table and the flag group that travels
// with every request through the pipeline.
// ============================================================================
package pbd_pkg;

    // Normalization: larger component of the vector lands in [2^40, 2^41)
    localparam int NORM_STEPS = 6;
    localparam int NORM_W     = 41;

    // Rotation datapath widths
    localparam int CORD_W = 44;
    localparam int Z_W    = 28;
    localparam int ATAN_W = 26;

    // Angle in degrees, 20 fraction bits; bearing out with 6 fraction bits
    localparam int ANG_FRAC  = 20;
    localparam int ANG_W     = 29;
    localparam int BEAR_W    = 15;
    localparam int OUT_SHIFT = ANG_FRAC - 6;

    localparam logic [ANG_W-1:0] DEG90      = ANG_W'(90 * 2**ANG_FRAC);
    localparam logic [ANG_W-1:0] DEG180     = ANG_W'(180 * 2**ANG_FRAC);
    localparam logic [ANG_W-1:0] DEG270     = ANG_W'(270 * 2**ANG_FRAC);
    localparam logic [ANG_W-1:0] DEG360     = ANG_W'(360 * 2**ANG_FRAC);
    localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(2**(OUT_SHIFT-1));

    localparam logic [BEAR_W-1:0] OUT_FULL_TURN = BEAR_W'(360 * 64);

    // round(atan(2^-i) * 180/pi * 2^20)
    localparam logic [ATAN_W-1:0] ATAN_Q20 [32] = '{
        26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121,
        26'd3750058,  26'd1876857,  26'd938658,   26'd469357,
        26'd234682,   26'd117342,   26'd58671,    26'd29335,
        26'd14668,    26'd7334,     26'd3667,     26'd1833,
        26'd917,      26'd458,      26'd229,      26'd115,
        26'd57,       26'd29,       26'd14,       26'd7,
        26'd4,        26'd2,        26'd1,        26'd0,
        26'd0,        26'd0,        26'd0,        26'd0
    };

    // Quadrant and axis information of the difference vector
    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic dx_zero;
        logic dy_zero;
    } flags_t;

endpackage

// ----- src/point_bearing_and_distance.sv -----
// ============================================================================
// point_bearing_and_distance: distance and bearing between two points
// Streaming block: integer Euclidean distance (rounded) from a start point to
// a target point, and the bearing toward it in degrees with 6 fraction bits.
// ============================================================================
//
// Usage:
//   Send a request on the s_ channel: start_x, start_y, end_x, end_y packed in
//   s_tdata. One result comes back on the m_ channel per request, in order:
//   distance and bearing (0 to 359.984 degrees, counter-clockwise from +x).
//   Coincident points give distance 0 and bearing 180.
// Pipeline: the input register, the six-step normalizer, the chain of
//   rotation/root cells, the quadrant register and the output register.
// Throughput: one request per cycle while the pipeline is not frozen by a
//   stall; every cell works on a different request.
// Reset: aresetn low clears all valid bits, the output valid included; data
//   registers, the output data register too, are not reset.
// Stall: the output register holds a result until m_tready. The pipeline
//   keeps moving while its last stage is empty, so bubbles close up; it
//   freezes, and s_tready drops, only when a result waits and the last stage
//   is also full.
//
module point_bearing_and_distance #(
    parameter int COORD_WIDTH     = 16,
    parameter int ROTATION_STAGES = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // s_tdata: start_x, start_y, end_x, end_y (COORD_WIDTH each), zero pad
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // m_tdata: distance (COORD_WIDTH+1), bearing (15), zero pad
    output logic [((COORD_WIDTH+16+7)/8)*8-1:0]        m_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready
);

    localparam int M_DATA_W   = ((COORD_WIDTH + 16 + 7) / 8) * 8;
    localparam int NCELL      = (ROTATION_STAGES > COORD_WIDTH + 1) ? ROTATION_STAGES
                                                                     : COORD_WIDTH + 1;
    localparam int PIPE_DEPTH = 1 + pbd_pkg::NORM_STEPS + NCELL + 1;
    localparam int CW         = pbd_pkg::CORD_W;
    localparam int ZW         = pbd_pkg::Z_W;
    localparam int RAD_W      = 2 * COORD_WIDTH + 2;
    localparam int REM_W      = COORD_WIDTH + 2;
    localparam int ROOT_W     = COORD_WIDTH + 1;

    logic                          adv;
    logic [PIPE_DEPTH-1:0]         vld_reg;
    logic                          m_tvalid_reg;
    logic [M_DATA_W-1:0]           m_tdata_reg;

    logic [pbd_pkg::NORM_W-1:0]    norm_x;
    logic [pbd_pkg::NORM_W-1:0]    norm_y;
    logic [RAD_W-1:0]              radicand;
    pbd_pkg::flags_t               front_flags;

    logic signed [CW-1:0]          cx    [NCELL+1];
    logic signed [CW-1:0]          cy    [NCELL+1];
    logic signed [ZW-1:0]          cz    [NCELL+1];
    logic [RAD_W-1:0]              crad  [NCELL+1];
    logic [REM_W-1:0]              crem  [NCELL+1];
    logic [ROOT_W-1:0]             croot [NCELL+1];
    pbd_pkg::flags_t               cflg  [NCELL+1];

    logic [ROOT_W-1:0]             distance;
    logic [pbd_pkg::BEAR_W-1:0]    bearing;

    // Move unless a result waits and the last stage is full
    assign adv      = !vld_reg[PIPE_DEPTH-1] || !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    pbd_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .adv      (adv),
        .start_x  ($signed(s_tdata[COORD_WIDTH-1:0])),
        .start_y  ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .end_x    ($signed(s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
        .end_y    ($signed(s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH])),
        .norm_x   (norm_x),
        .norm_y   (norm_y),
        .radicand (radicand),
        .flags    (front_flags)
    );

    // Seed the cell chain
    assign cx[0]    = $signed(CW'(norm_x));
    assign cy[0]    = $signed(CW'(norm_y));
    assign cz[0]    = '0;
    assign crad[0]  = radicand;
    assign crem[0]  = '0;
    assign croot[0] = '0;
    assign cflg[0]  = front_flags;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        pbd_cell #(
            .COORD_WIDTH     (COORD_WIDTH),
            .ROTATION_STAGES (ROTATION_STAGES),
            .IDX             (i)
        ) u_cell (
            .aclk      (aclk),
            .adv       (adv),
            .x_in      (cx[i]),
            .y_in      (cy[i]),
            .z_in      (cz[i]),
            .rad_in    (crad[i]),
            .rem_in    (crem[i]),
            .root_in   (croot[i]),
            .flags_in  (cflg[i]),
            .x_out     (cx[i+1]),
            .y_out     (cy[i+1]),
            .z_out     (cz[i+1]),
            .rad_out   (crad[i+1]),
            .rem_out   (crem[i+1]),
            .root_out  (croot[i+1]),
            .flags_out (cflg[i+1])
        );
    end

    pbd_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .adv      (adv),
        .z_in     (cz[NCELL]),
        .rem_in   (crem[NCELL]),
        .root_in  (croot[NCELL]),
        .flags_in (cflg[NCELL]),
        .distance (distance),
        .bearing  (bearing)
    );

    // Track which stages hold a request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // Load the output register from the last stage, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv && vld_reg[PIPE_DEPTH-1]) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vld_reg[PIPE_DEPTH-1]) begin
            m_tdata_reg <= M_DATA_W'({bearing, distance});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- src/pbd_front.sv -----
// ============================================================================
// pbd_front: difference, magnitude, normalization and squares
// Forms the difference vector, normalizes its absolute components with a
// pipelined leading-zero shifter and builds the sum of squares for the root.
// ============================================================================
module pbd_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            adv,
    input  logic signed [COORD_WIDTH-1:0]   start_x,
    input  logic signed [COORD_WIDTH-1:0]   start_y,
    input  logic signed [COORD_WIDTH-1:0]   end_x,
    input  logic signed [COORD_WIDTH-1:0]   end_y,
    output logic [pbd_pkg::NORM_W-1:0]      norm_x,
    output logic [pbd_pkg::NORM_W-1:0]      norm_y,
    output logic [2*COORD_WIDTH+1:0]        radicand,
    output pbd_pkg::flags_t                 flags
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int RAD_W  = 2 * DIFF_W;
    localparam int NS     = pbd_pkg::NORM_STEPS;
    localparam int NW     = pbd_pkg::NORM_W;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;
    pbd_pkg::flags_t          flg_now;
    logic [NS-1:0]            fit;

    logic [NW-1:0]     nx_reg  [NS+1];
    logic [NW-1:0]     ny_reg  [NS+1];
    pbd_pkg::flags_t   flg_reg [NS+1];
    logic [RAD_W-1:0]  sq_x_reg;
    logic [RAD_W-1:0]  sq_y_reg;
    logic [RAD_W-1:0]  rad_reg [NS-1];

    // Difference vector and its absolute components
    always_comb begin
        dx = DIFF_W'(end_x) - DIFF_W'(start_x);
        dy = DIFF_W'(end_y) - DIFF_W'(start_y);
        ax = dx[DIFF_W-1] ? $unsigned(-dx) : $unsigned(dx);
        ay = dy[DIFF_W-1] ? $unsigned(-dy) : $unsigned(dy);
        flg_now.dx_neg  = dx[DIFF_W-1];
        flg_now.dy_neg  = dy[DIFF_W-1];
        flg_now.dx_zero = (dx == '0);
        flg_now.dy_zero = (dy == '0);
    end

    // Shift by 32, 16, ... 1 wherever the vector still fits below the top
    always_comb begin
        for (int j = 0; j < NS; j++) begin
            fit[j] = ~|((nx_reg[j] | ny_reg[j]) >> (NW - (1 << (NS - 1 - j))));
        end
    end

    // Advance the normalizer and the sum of squares
    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg[0]  <= NW'(ax);
            ny_reg[0]  <= NW'(ay);
            flg_reg[0] <= flg_now;
            for (int j = 0; j < NS; j++) begin
                nx_reg[j+1]  <= fit[j] ? (nx_reg[j] << (1 << (NS - 1 - j))) : nx_reg[j];
                ny_reg[j+1]  <= fit[j] ? (ny_reg[j] << (1 << (NS - 1 - j))) : ny_reg[j];
                flg_reg[j+1] <= flg_reg[j];
            end
            sq_x_reg   <= RAD_W'(nx_reg[0][DIFF_W-1:0]) * RAD_W'(nx_reg[0][DIFF_W-1:0]);
            sq_y_reg   <= RAD_W'(ny_reg[0][DIFF_W-1:0]) * RAD_W'(ny_reg[0][DIFF_W-1:0]);
            rad_reg[0] <= sq_x_reg + sq_y_reg;
            for (int k = 1; k < NS - 1; k++) begin
                rad_reg[k] <= rad_reg[k-1];
            end
        end
    end

    assign norm_x   = nx_reg[NS];
    assign norm_y   = ny_reg[NS];
    assign flags    = flg_reg[NS];
    assign radicand = rad_reg[NS-2];

endmodule

// ----- src/pbd_cell.sv -----
// ============================================================================
// pbd_cell: one link of the rotation and root chain
// Performs one vectoring rotation and one digit of the square root, then
// hands the whole request to the next cell. Cells past the last rotation or
// past the last root digit pass that part through unchanged.
// ============================================================================
module pbd_cell #(
    parameter int COORD_WIDTH     = 16,
    parameter int ROTATION_STAGES = 16,
    parameter int IDX             = 0
) (
    input  logic                                aclk,
    input  logic                                adv,
    input  logic signed [pbd_pkg::CORD_W-1:0]   x_in,
    input  logic signed [pbd_pkg::CORD_W-1:0]   y_in,
    input  logic signed [pbd_pkg::Z_W-1:0]      z_in,
    input  logic [2*COORD_WIDTH+1:0]            rad_in,
    input  logic [COORD_WIDTH+1:0]              rem_in,
    input  logic [COORD_WIDTH:0]                root_in,
    input  pbd_pkg::flags_t                     flags_in,
    output logic signed [pbd_pkg::CORD_W-1:0]   x_out,
    output logic signed [pbd_pkg::CORD_W-1:0]   y_out,
    output logic signed [pbd_pkg::Z_W-1:0]      z_out,
    output logic [2*COORD_WIDTH+1:0]            rad_out,
    output logic [COORD_WIDTH+1:0]              rem_out,
    output logic [COORD_WIDTH:0]                root_out,
    output pbd_pkg::flags_t                     flags_out
);

    localparam int CW     = pbd_pkg::CORD_W;
    localparam int ZW     = pbd_pkg::Z_W;
    localparam int ROOT_W = COORD_WIDTH + 1;
    localparam int REM_W  = COORD_WIDTH + 2;
    localparam int RAD_W  = 2 * COORD_WIDTH + 2;

    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [ZW-1:0] z_next;
    logic [RAD_W-1:0]     rad_next;
    logic [REM_W-1:0]     rem_next;
    logic [ROOT_W-1:0]    root_next;

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    pbd_pkg::flags_t      flg_reg;

    // Rotate toward the x axis, accumulating the angle
    if (IDX < ROTATION_STAGES) begin : g_rot
        localparam logic signed [ZW-1:0] STEP_ANGLE = ZW'(pbd_pkg::ATAN_Q20[IDX]);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        always_comb begin
            xs = x_in >>> IDX;
            ys = y_in >>> IDX;
            if (!y_in[CW-1]) begin
                x_next = x_in + ys;
                y_next = y_in - xs;
                z_next = z_in + STEP_ANGLE;
            end else begin
                x_next = x_in - ys;
                y_next = y_in + xs;
                z_next = z_in - STEP_ANGLE;
            end
        end
    end else begin : g_rot_hold
        assign x_next = x_in;
        assign y_next = y_in;
        assign z_next = z_in;
    end

    // Take the next bit pair of the radicand and settle one root digit
    if (IDX < ROOT_W) begin : g_root
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        always_comb begin
            rem_sh   = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial    = {1'b0, root_in, 2'b01};
            rad_next = rad_in << 2;
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end else begin : g_root_hold
        assign rad_next  = rad_in;
        assign rem_next  = rem_in;
        assign root_next = root_in;
    end

    // Hand the request to the next cell
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            flg_reg  <= flags_in;
        end
    end

    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign flags_out = flg_reg;

endmodule

// ----- src/pbd_back.sv -----
// ============================================================================
// pbd_back: quadrant mapping and output rounding
// Clamps the first-quadrant angle, maps it to a full-turn bearing, rounds the
// root to nearest, then rounds the bearing to 1/64 degree and wraps 360 to 0.
// ============================================================================
module pbd_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            adv,
    input  logic signed [pbd_pkg::Z_W-1:0]  z_in,
    input  logic [COORD_WIDTH+1:0]          rem_in,
    input  logic [COORD_WIDTH:0]            root_in,
    input  pbd_pkg::flags_t                 flags_in,
    output logic [COORD_WIDTH:0]            distance,
    output logic [pbd_pkg::BEAR_W-1:0]      bearing
);

    localparam int AW     = pbd_pkg::ANG_W;
    localparam int ZW     = pbd_pkg::Z_W;
    localparam int BW     = pbd_pkg::BEAR_W;
    localparam int ROOT_W = COORD_WIDTH + 1;
    localparam int REM_W  = COORD_WIDTH + 2;

    logic [AW-1:0]     a;
    logic [AW-1:0]     ang_next;
    logic [ROOT_W-1:0] dist_next;
    logic [AW-1:0]     ang_reg;
    logic [ROOT_W-1:0] dist_reg;
    logic [AW-1:0]     rounded;
    logic [BW-1:0]     coarse;

    // Clamp the angle and place it in its quadrant
    always_comb begin
        if (flags_in.dy_zero) begin
            a = '0;
        end else if (flags_in.dx_zero) begin
            a = pbd_pkg::DEG90;
        end else if (z_in[ZW-1]) begin
            a = '0;
        end else if (AW'(z_in[ZW-2:0]) > pbd_pkg::DEG90) begin
            a = pbd_pkg::DEG90;
        end else begin
            a = AW'(z_in[ZW-2:0]);
        end

        if (!flags_in.dy_neg && (flags_in.dx_neg || flags_in.dx_zero)) begin
            ang_next = pbd_pkg::DEG180 - a;
        end else if (flags_in.dy_neg && flags_in.dx_neg) begin
            ang_next = pbd_pkg::DEG180 + a;
        end else if (flags_in.dy_neg && !flags_in.dx_zero) begin
            ang_next = pbd_pkg::DEG360 - a;
        end else if (flags_in.dy_neg) begin
            ang_next = pbd_pkg::DEG270;
        end else begin
            ang_next = a;
        end

        // Round the root up when the remainder exceeds it
        dist_next = root_in + ROOT_W'(rem_in > REM_W'(root_in));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_reg  <= ang_next;
            dist_reg <= dist_next;
        end
    end

    // Round to 1/64 degree and wrap a full turn to zero
    always_comb begin
        rounded = ang_reg + pbd_pkg::ROUND_HALF;
        coarse  = rounded[AW-1 -: BW];
        bearing = (coarse >= pbd_pkg::OUT_FULL_TURN) ? coarse - pbd_pkg::OUT_FULL_TURN
                                                     : coarse;
    end

    assign distance = dist_reg;

endmodule

// ----- src/pbd_checker.sv -----
// ============================================================================
// pbd_checker: port-level checks for the bearing and distance block
// Watches the stream ports of the top level and flags stalls, reset and
// result values that the block can never produce.
// ============================================================================
module pbd_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [((COORD_WIDTH+16+7)/8)*8-1:0]   m_tdata,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready
);

    localparam logic [pbd_pkg::BEAR_W-1:0] HALF_TURN = pbd_pkg::OUT_FULL_TURN / 2;

    logic [COORD_WIDTH:0]           distance;
    logic [pbd_pkg::BEAR_W-1:0]     bearing;

    assign distance = m_tdata[COORD_WIDTH:0];
    assign bearing  = m_tdata[COORD_WIDTH+1 +: pbd_pkg::BEAR_W];

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // Clear the result channel at reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Refuse a request only behind a stalled result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request refused while output side is free");

    // Keep the bearing below a full turn
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> bearing < pbd_pkg::OUT_FULL_TURN)
        else $error("bearing out of range");

    // Zero distance means coincident points, which face 180 degrees
    a_coincide: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && distance == '0 |-> bearing == HALF_TURN)
        else $error("coincident points without a 180 degree bearing");

endmodule

bind point_bearing_and_distance pbd_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_pbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
